/* src/i2c_ram_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_ram_pkg
// shared types and constants of the i2c register access master
// ----------------------------------------------------------------------------
package i2c_ram_pkg;

    localparam int MAX_BURST_DEFAULT = 16;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD    = 1'b1;

    localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd81;
    localparam logic [15:0] HALF_PERIOD_RESET    = 16'd50;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_READ      = 1'b1;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START    = 5'd1,
        PH_TX_DEVW  = 5'd2,
        PH_ACK_DEVW = 5'd3,
        PH_TX_REG   = 5'd4,
        PH_ACK_REG  = 5'd5,
        PH_TX_DATA  = 5'd6,
        PH_ACK_DATA = 5'd7,
        PH_RSTART   = 5'd8,
        PH_TX_DEVR  = 5'd9,
        PH_ACK_DEVR = 5'd10,
        PH_RX       = 5'd11,
        PH_TX_MACK  = 5'd12,
        PH_STOP     = 5'd13
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic       op;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [4:0] read_count;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_enable;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_data;
        logic       byte_last;
        logic       nack_seen;
    } result_t;

    typedef struct packed {
        logic [6:0]  device_address;
        logic [15:0] half_period_ticks;
    } cfg_t;

endpackage : i2c_ram_pkg
`default_nettype wire

/* src/i2c_ram_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_ram_cfg
// configuration registers: target address and half bit period
// ----------------------------------------------------------------------------
module i2c_ram_cfg
    import i2c_ram_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    logic [6:0]  dev_addr_reg;
    logic [15:0] half_period_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg    <= DEVICE_ADDRESS_RESET;
            half_period_reg <= HALF_PERIOD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: dev_addr_reg    <= cfg_data[6:0];
                REG_HALF_PERIOD:    half_period_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.device_address    = dev_addr_reg;
    assign cfg.half_period_ticks = half_period_reg;

endmodule : i2c_ram_cfg
`default_nettype wire

/* src/i2c_ram_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_ram_core
// bus sequencer state and the per-word step logic
// ----------------------------------------------------------------------------
module i2c_ram_core
    import i2c_ram_pkg::*;
#(
    parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  step,
    input  wire item_t item,
    output result_t    result
);

    localparam int LW = $clog2(MAX_BURST + 1);
    localparam int CW = (LW > 5) ? LW : 5;

    phase_t          phase_reg, phase_next;
    logic [15:0]     tick_reg, tick_next;
    logic [3:0]      bit_reg, bit_next;
    logic [7:0]      shift_reg, shift_next;
    logic [LW-1:0]   left_reg, left_next;
    logic            op_reg, op_next;
    logic [7:0]      sreg_reg, sreg_next;
    logic [7:0]      sdata_reg, sdata_next;
    logic            nack_reg, nack_next;

    logic [16:0]     hp;
    logic [16:0]     tick_inc;
    logic [7:0]      shift_tmp;
    logic [7:0]      dev;
    logic [3:0]      last_half;
    logic [CW-1:0]   cnt;
    logic [LW-1:0]   left_dec;
    logic            rx_valid;
    logic [7:0]      rx_data;
    logic            rx_last;
    phase_t          pin_phase;
    logic [3:0]      pin_bit;
    logic            pin_msb;
    logic            pin_left_one;
    logic            scl, sda, en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            left_reg  <= '0;
            op_reg    <= 1'b0;
            sreg_reg  <= '0;
            sdata_reg <= '0;
            nack_reg  <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            op_reg    <= op_next;
            sreg_reg  <= sreg_next;
            sdata_reg <= sdata_next;
            nack_reg  <= nack_next;
        end
    end

    assign dev      = {cfg.device_address, 1'b0};
    assign hp       = (cfg.half_period_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.half_period_ticks};
    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign left_dec = (left_reg != '0) ? left_reg - LW'(1) : left_reg;

    always_comb begin
        case (phase_reg)
            PH_START, PH_RSTART, PH_STOP: last_half = 4'd2;
            PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR, PH_RX: last_half = 4'd15;
            default: last_half = 4'd1;
        endcase
    end

    always_comb begin
        cnt = CW'(item.read_count);
        if (cnt == '0) cnt = CW'(1);
        if (cnt > CW'(MAX_BURST)) cnt = CW'(MAX_BURST);
    end

    // next state: command start, or end of a half bit period; else count ticks
    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        op_next    = op_reg;
        sreg_next  = sreg_reg;
        sdata_next = sdata_reg;
        nack_next  = nack_reg;
        shift_tmp  = shift_reg;
        rx_valid   = 1'b0;
        rx_data    = '0;
        rx_last    = 1'b0;

        if (item.kind == KIND_COMMAND) begin
            if (phase_reg == PH_IDLE) begin
                op_next    = item.op;
                sreg_next  = item.reg_addr;
                sdata_next = item.write_data;
                left_next  = LW'(cnt);
                nack_next  = 1'b0;
                tick_next  = '0;
                phase_next = PH_START;
                bit_next   = '0;
                shift_next = '0;
            end
        end else if (phase_reg != PH_IDLE) begin
            if (tick_inc >= hp) begin
                tick_next = '0;
                case (phase_reg)
                    PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR:
                        if (bit_reg[0]) shift_tmp = {shift_reg[6:0], 1'b0};
                    PH_ACK_DEVW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR:
                        if (bit_reg[0]) nack_next = nack_reg | item.sda_in;
                    PH_RX:
                        if (bit_reg[0]) shift_tmp = {shift_reg[6:0], item.sda_in};
                    default: ;
                endcase

                if (bit_reg != last_half) begin
                    bit_next   = bit_reg + 4'd1;
                    shift_next = shift_tmp;
                end else begin
                    bit_next   = '0;
                    shift_next = '0;
                    case (phase_reg)
                        PH_START: begin
                            phase_next = PH_TX_DEVW;
                            shift_next = dev;
                        end
                        PH_TX_DEVW: phase_next = PH_ACK_DEVW;
                        PH_ACK_DEVW: begin
                            phase_next = PH_TX_REG;
                            shift_next = sreg_reg;
                        end
                        PH_TX_REG: phase_next = PH_ACK_REG;
                        PH_ACK_REG: begin
                            if (op_reg == OP_WRITE) begin
                                phase_next = PH_TX_DATA;
                                shift_next = sdata_reg;
                            end else begin
                                phase_next = PH_RSTART;
                            end
                        end
                        PH_TX_DATA:  phase_next = PH_ACK_DATA;
                        PH_ACK_DATA: phase_next = PH_STOP;
                        PH_RSTART: begin
                            phase_next = PH_TX_DEVR;
                            shift_next = dev | 8'h01;
                        end
                        PH_TX_DEVR:  phase_next = PH_ACK_DEVR;
                        PH_ACK_DEVR: phase_next = PH_RX;
                        PH_RX: begin
                            rx_valid   = 1'b1;
                            rx_data    = shift_tmp;
                            rx_last    = (left_reg <= LW'(1));
                            phase_next = PH_TX_MACK;
                            shift_next = shift_tmp;
                        end
                        PH_TX_MACK: begin
                            left_next  = left_dec;
                            phase_next = (left_dec == '0) ? PH_STOP : PH_RX;
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end else begin
                tick_next = tick_inc[15:0];
            end
        end
    end

    // a tick shows the pins before it advances, a command the pins after it
    always_comb begin
        if (item.kind == KIND_COMMAND) begin
            pin_phase    = phase_next;
            pin_bit      = bit_next;
            pin_msb      = shift_next[7];
            pin_left_one = (left_next == LW'(1));
        end else begin
            pin_phase    = phase_reg;
            pin_bit      = bit_reg;
            pin_msb      = shift_reg[7];
            pin_left_one = (left_reg == LW'(1));
        end
    end

    always_comb begin
        scl = 1'b1;
        sda = 1'b1;
        en  = 1'b1;
        case (pin_phase)
            PH_START, PH_RSTART: begin
                scl = (pin_bit != 4'd0);
                sda = (pin_bit != 4'd2);
            end
            PH_STOP: begin
                scl = (pin_bit != 4'd0);
                sda = (pin_bit == 4'd2);
            end
            PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR: begin
                scl = pin_bit[0];
                sda = pin_msb;
            end
            PH_ACK_DEVW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR, PH_RX: begin
                scl = pin_bit[0];
                en  = 1'b0;
            end
            PH_TX_MACK: begin
                scl = pin_bit[0];
                sda = pin_left_one;
            end
            default: ;
        endcase
    end

    assign result.scl        = scl;
    assign result.sda_out    = en ? sda : 1'b1;
    assign result.sda_enable = en;
    assign result.busy_res   = (phase_next != PH_IDLE);
    assign result.byte_valid = rx_valid;
    assign result.byte_data  = rx_data;
    assign result.byte_last  = rx_last;
    assign result.nack_seen  = nack_next;

endmodule : i2c_ram_core
`default_nettype wire

/* src/i2c_ram_out.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_ram_out
// result register with a skid stage
// ----------------------------------------------------------------------------
module i2c_ram_out
    import i2c_ram_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_result,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_result
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;

    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            out_reg <= skid_valid_reg ? skid_reg : in_result;
        end else if (in_valid && !skid_valid_reg) begin
            skid_reg <= in_result;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

endmodule : i2c_ram_out
`default_nettype wire

/* src/i2c_register_access_master_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_access_master_unit
// i2c master for single register writes and burst register reads
// ----------------------------------------------------------------------------
// usage
//  - s_ channel: one word per system tick (kind tick, carries the sda sample)
//    or a command word (kind command) that starts a write or a burst read;
//    a command is ignored while a transaction runs
//  - m_ channel: exactly one result word per input word, carrying the scl and
//    sda pin levels, busy, nack flag and any byte completed on that word
//  - cfg port: device address and half period length in ticks; takes effect
//    from the next word; write only while no word is in flight (not enforced)
//  - each result word is registered; on a stall it waits in the skid register
//  - one word per cycle unless stalled; the whole step is the sequencer's
//    next-state logic between the state registers and the result register
//  - when the receiver stalls, one more word is taken into a skid register,
//    then s_ready drops until the result register drains
//  - reset (aresetn low, synchronous) returns the sequencer to idle, clears
//    the result and skid stages and restores the configuration defaults
// ----------------------------------------------------------------------------
module i2c_register_access_master_unit
    import i2c_ram_pkg::*;
#(
    parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input words
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire item_t                  s_item,
    // result words
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output result_t                     m_result,
    // configuration writes
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t step_result;
    logic    step;

    // a word is stepped through the sequencer at the edge it is taken
    assign step = s_valid && s_ready;

    i2c_ram_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: phase, half-period counter, shift register, burst count
    i2c_ram_core #(
        .MAX_BURST (MAX_BURST)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (step),
        .item    (s_item),
        .result  (step_result)
    );

    // result register plus skid stage decouples s_ready from a stalled sink
    i2c_ram_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step),
        .in_ready  (s_ready),
        .in_result (step_result),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_result  (m_result)
    );

endmodule : i2c_register_access_master_unit
`default_nettype wire
